### hdl/sensor_frame_deframer_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sensor frame deframer
// Shared forms of clocked, reset-qualified checks.
// ---------------------------------------------------------------------------
`ifndef SENSOR_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define SENSOR_FRAME_DEFRAMER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sfd_pkg.sv
// ---------------------------------------------------------------------------
// Sensor frame deframer package
// Types and constants shared by the deframer RTL.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

	localparam int SENSORS_PER_SET = 8;
	localparam int CNT_W = 3;
	localparam int ID_W = 3;
	localparam int LEVEL_W = 10;

	localparam logic [7:0] STOP_FIRST = 8'hFF;
	localparam logic [7:0] STOP_SECOND = 8'h3F;
	localparam logic [ID_W-1:0] LAST_ID = ID_W'(SENSORS_PER_SET - 1);

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_TIME = 2'd1,
		KIND_STOP = 2'd2
	} kind_t;

	typedef struct packed {
		logic set_marked;
		logic set_done;
		logic [LEVEL_W-1:0] level_value;
		logic [ID_W-1:0] sensor_id;
		kind_t frame_kind;
	} result_t;

endpackage

`default_nettype wire

### hdl/sensor_frame_deframer_core.sv
// ---------------------------------------------------------------------------
// Sensor frame deframer
// Parses two-byte sensor frames from a byte stream into sample, timestamp
// and stop items.
// ---------------------------------------------------------------------------
// A byte that completes a frame is captured in the input register, and its result is
// then loaded into the result register when that register is empty or being taken.
// Throughput: one byte per cycle; both registers advance together whenever
// the result register is empty or being taken.
// Reset: arst_n clears the held byte flag, start flag, marker and set count.
`timescale 1ns / 1ps
`default_nettype none

`include "sensor_frame_deframer_core_assert.svh"

module sensor_frame_deframer_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata, // [7:0] rx_byte
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [15:0] m_tdata, // [2:0] sensor_id, [12:3] level_value, [13] set_done,
	                             // [14] set_marked, [15] zero
	output logic [1:0] m_tuser   // [1:0] frame_kind
);

	logic in_valid_s1;
	logic [7:0] in_byte_s1;
	logic out_valid_s2;
	sfd_pkg::result_t out_res_s2;

	logic holding_q;
	logic [7:0] held_q;
	logic started_q;
	logic pending_q;
	logic [sfd_pkg::CNT_W-1:0] samples_q;

	logic out_free;
	logic adv;
	logic res_valid;
	sfd_pkg::result_t res;
	logic holding_d;
	logic [7:0] held_d;
	logic started_d;
	logic pending_d;
	logic [sfd_pkg::CNT_W-1:0] samples_d;
	logic mark;
	logic [sfd_pkg::CNT_W:0] cnt;

	assign out_free = !out_valid_s2 || m_tready;
	assign s_tready = !in_valid_s1 || out_free;
	assign adv = in_valid_s1 && out_free;

	always_comb begin
		holding_d = holding_q;
		held_d = held_q;
		started_d = started_q;
		pending_d = pending_q;
		samples_d = samples_q;
		res_valid = 1'b0;
		res = '0;
		mark = pending_q | in_byte_s1[6];
		cnt = {1'b0, samples_q} + {{sfd_pkg::CNT_W{1'b0}}, 1'b1};
		if (!holding_q) begin
			held_d = in_byte_s1;
			holding_d = 1'b1;
		end else if (held_q == sfd_pkg::STOP_FIRST && in_byte_s1 == sfd_pkg::STOP_SECOND) begin
			holding_d = 1'b0;
			if (!started_q) begin
				started_d = 1'b1;
			end else begin
				started_d = 1'b0;
				pending_d = 1'b0;
				samples_d = '0;
				res_valid = 1'b1;
				res.frame_kind = sfd_pkg::KIND_STOP;
			end
		end else if (!held_q[7] || in_byte_s1[7]) begin
			held_d = in_byte_s1;
		end else begin
			holding_d = 1'b0;
			pending_d = mark;
			if (!started_q) begin
				started_d = 1'b1;
			end else begin
				res_valid = 1'b1;
				res.sensor_id = held_q[6:4];
				res.level_value = {held_q[3:0], in_byte_s1[5:0]};
				if (mark && held_q[6:4] == sfd_pkg::LAST_ID) begin
					pending_d = 1'b0;
					res.frame_kind = sfd_pkg::KIND_TIME;
				end else begin
					res.frame_kind = sfd_pkg::KIND_SAMPLE;
					if (cnt >= (sfd_pkg::CNT_W + 1)'(sfd_pkg::SENSORS_PER_SET)) begin
						samples_d = '0;
						res.set_done = 1'b1;
						res.set_marked = mark;
						pending_d = 1'b0;
					end else begin
						samples_d = cnt[sfd_pkg::CNT_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_s2 <= 1'b0;
			holding_q <= 1'b0;
			held_q <= '0;
			started_q <= 1'b0;
			pending_q <= 1'b0;
			samples_q <= '0;
		end else begin
			if (s_tready) begin
				in_valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				out_valid_s2 <= adv && res_valid;
			end
			if (adv) begin
				holding_q <= holding_d;
				held_q <= held_d;
				started_q <= started_d;
				pending_q <= pending_d;
				samples_q <= samples_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
		end
		if (adv && res_valid) begin
			out_res_s2 <= res;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tuser = out_res_s2.frame_kind;
	assign m_tdata = {1'b0, out_res_s2.set_marked, out_res_s2.set_done,
		out_res_s2.level_value, out_res_s2.sensor_id};

	`SFD_ASSERT_SAME(a_stop_empty, clk, arst_n,
		m_tvalid && m_tuser == sfd_pkg::KIND_STOP, m_tdata == '0,
		"Stop item carries nonzero payload.")
	`SFD_ASSERT_SAME(a_marked_needs_done, clk, arst_n,
		m_tvalid && m_tdata[14], m_tdata[13] && m_tuser == sfd_pkg::KIND_SAMPLE,
		"Marked flag without a completed set.")
	`SFD_ASSERT_SAME(a_count_range, clk, arst_n, 1'b1,
		samples_q <= sfd_pkg::CNT_W'(sfd_pkg::SENSORS_PER_SET - 1),
		"Set count out of range.")
	`SFD_ASSERT_NEXT(a_stop_clears, clk, arst_n,
		adv && res_valid && res.frame_kind == sfd_pkg::KIND_STOP,
		!started_q && !pending_q && samples_q == '0,
		"Stop frame did not clear stream state.")
	`SFD_ASSERT_NEXT(a_result_lands, clk, arst_n, adv && res_valid, m_tvalid,
		"Result was not loaded into the output register.")

endmodule

`default_nettype wire

### tb/sv/tb_sensor_frame_deframer_core.sv
// ---------------------------------------------------------------------------
// Testbench for the sensor frame deframer
// Feeds byte streams through the slave stream port and checks every result
// item against an in-bench frame decoder. The stimulus covers a directed run
// of the special frames, long receiver back-pressure, a drained sender pause,
// and random traffic with noise and broken pairs, first with idle bursts on
// both sides and then at full rate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_sensor_frame_deframer_core;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0] m_tuser;

	// Frame decoder state.
	bit hold_valid;
	logic [7:0] hold_byte;
	bit started;
	bit marker;
	int unsigned set_count;

	sfd_pkg::result_t expected_frames[$];
	sfd_pkg::result_t want_frame;

	bit tx_idle_on;
	bit rx_idle_on;
	int long_hold_cycles;
	int errors;
	int cycles;
	int bytes_sent;
	int n_samples, n_sets, n_times, n_stops;

	sensor_frame_deframer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: timeout", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic decode_byte(input logic [7:0] b);
		sfd_pkg::result_t res;
		logic [7:0] first;
		int unsigned count;
		res = '0;
		if (!hold_valid) begin
			hold_valid = 1'b1;
			hold_byte = b;
			return;
		end
		first = hold_byte;
		if (first == sfd_pkg::STOP_FIRST && b == sfd_pkg::STOP_SECOND) begin
			hold_valid = 1'b0;
			if (!started) begin
				started = 1'b1;
				return;
			end
			started = 1'b0;
			marker = 1'b0;
			set_count = 0;
			res.frame_kind = sfd_pkg::KIND_STOP;
			expected_frames.push_back(res);
			return;
		end
		// A bad pair drops the first byte and keeps the second as a new first byte.
		if (!first[7] || b[7]) begin
			hold_byte = b;
			return;
		end
		hold_valid = 1'b0;
		if (b[6])
			marker = 1'b1;
		if (!started) begin
			started = 1'b1;
			return;
		end
		res.sensor_id = first[6:4];
		res.level_value = {first[3:0], b[5:0]};
		if (marker && res.sensor_id == sfd_pkg::LAST_ID) begin
			marker = 1'b0;
			res.frame_kind = sfd_pkg::KIND_TIME;
			expected_frames.push_back(res);
			return;
		end
		res.frame_kind = sfd_pkg::KIND_SAMPLE;
		count = set_count + 1;
		if (count >= sfd_pkg::SENSORS_PER_SET) begin
			set_count = 0;
			res.set_done = 1'b1;
			res.set_marked = marker;
			marker = 1'b0;
		end else begin
			set_count = count;
		end
		expected_frames.push_back(res);
	endtask

	task automatic send_byte(input logic [7:0] b);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		decode_byte(b);
		bytes_sent++;
	endtask

	task automatic send_valid_frame();
		logic [6:0] head;
		logic [5:0] low;
		head = 7'($urandom_range(0, 127));
		low = 6'($urandom_range(0, 63));
		send_byte({1'b1, head});
		send_byte({1'b0, ($urandom_range(0, 3) == 0), low});
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_frames.size() == 0) begin
				$display("%0t ns: unexpected item, expected none, actual kind %0d data %h",
					$time, m_tuser, m_tdata);
				errors++;
			end else begin
				want_frame = expected_frames.pop_front();
				check_field("frame_kind", want_frame.frame_kind, m_tuser);
				check_field("sensor_id", want_frame.sensor_id, m_tdata[2:0]);
				check_field("level_value", want_frame.level_value, m_tdata[12:3]);
				check_field("set_done", want_frame.set_done, m_tdata[13]);
				check_field("set_marked", want_frame.set_marked, m_tdata[14]);
				check_field("padding", 0, m_tdata[15]);
				case (want_frame.frame_kind)
					sfd_pkg::KIND_SAMPLE: begin
						n_samples++;
						if (want_frame.set_done)
							n_sets++;
					end
					sfd_pkg::KIND_TIME: n_times++;
					default: n_stops++;
				endcase
			end
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (long_hold_cycles) @(posedge clk);
				long_hold_cycles = 0;
				m_tready <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic test_directed_frames();
		logic [7:0] seq[] = '{
			8'hFF, 8'h3F,           // stop frame swallowed as the first frame
			8'h80, 8'h00,           // lowest sample
			8'h12, 8'h85, 8'h90,    // bad first byte, then bad second byte
			8'h01,                  // completes a frame with the held 0x90
			8'hFF, 8'h7F,           // marked last id gives a timestamp, top level
			8'hC5, 8'h40,           // marked sample leaves the marker pending
			8'hFF, 8'h3F,           // stop frame after start
			8'hBF, 8'h7F,           // swallowed frame still sets the marker
			8'hF0, 8'h3F,           // last id with pending marker is a timestamp
			8'hFF, 8'h3F            // stop again
		};
		foreach (seq[i])
			send_byte(seq[i]);
		wait_drain();
	endtask

	task automatic test_backpressure();
		long_hold_cycles = 80;
		repeat (30)
			send_valid_frame();
		wait_drain();
	endtask

	task automatic test_sender_pause();
		repeat (12)
			send_valid_frame();
		wait_drain();
		repeat (12)
			send_valid_frame();
		wait_drain();
	endtask

	task automatic test_random_traffic(input int n_bytes);
		int target;
		int pick;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				send_valid_frame();
			end else if (pick < 76) begin
				send_byte(sfd_pkg::STOP_FIRST);
				send_byte(sfd_pkg::STOP_SECOND);
			end else if (pick < 88) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_byte({1'b0, 7'($urandom_range(0, 127))});
				send_byte({1'b1, 7'($urandom_range(0, 127))});
			end
		end
		wait_drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		test_backpressure();
		test_sender_pause();
		test_random_traffic(800);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_random_traffic(400);

		$display("Sent %0d bytes; checked %0d samples (%0d full sets), %0d timestamps, %0d stops.",
			bytes_sent, n_samples, n_sets, n_times, n_stops);
		$display("Covered swallowed frames, bad pairs, markers, back-pressure and idle bursts.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
